FILE: src/bpfla_pkg.sv
// Shared constants, types and codes of the byte pool free list allocator.
`default_nettype none
package bpfla_pkg;

	localparam int unsigned POOL_BYTES   = 65536;
	localparam int unsigned MIN_POOL     = 25;
	localparam int unsigned HEADER_BYTES = 24;
	localparam int unsigned SPLIT_SLACK  = 8;
	localparam int unsigned FREE_ENTRIES = 32;
	localparam int unsigned LIVE_ENTRIES = 64;

	localparam int unsigned BYTE_W = 17;
	localparam int unsigned OFFS_W = 16;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned FIDX_W = $clog2(FREE_ENTRIES);
	localparam int unsigned FCNT_W = $clog2(FREE_ENTRIES + 1);
	localparam int unsigned LIDX_W = $clog2(LIVE_ENTRIES);
	localparam int unsigned LCNT_W = $clog2(LIVE_ENTRIES + 1);

	typedef logic [BYTE_W-1:0] bytes_t;
	typedef logic [OFFS_W-1:0] offs_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REALLOC = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_REJECTED  = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_FREE_FULL = 3'd3,
		ST_LIVE_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TK_REMOVE,
		TK_SHRINK,
		TK_STACK
	} take_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LSRCH,
		S_SLOT,
		S_FSCAN,
		S_TCOMMIT,
		S_RCHK,
		S_INS,
		S_DONE
	} fsm_t;

	// One live table row: header offset and block bytes
	typedef struct packed {
		offs_t  hdr;
		bytes_t blk;
	} live_entry_t;

endpackage
`default_nettype wire

FILE: src/bpfla_cmd_if.sv
// Request channel: operation and its operands.
`default_nettype none
interface bpfla_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [bpfla_pkg::OP_W-1:0]       operation;
	logic [bpfla_pkg::BYTE_W-1:0]     request_bytes;
	logic [bpfla_pkg::BYTE_W-1:0]     block_offset;
	logic                             has_pointer;

	modport source(output valid, operation, request_bytes, block_offset, has_pointer,
		input ready);
	modport sink(input valid, operation, request_bytes, block_offset, has_pointer,
		output ready);
endinterface
`default_nettype wire

FILE: src/bpfla_rsp_if.sv
// Result channel: status, offsets and remaining bytes.
`default_nettype none
interface bpfla_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [bpfla_pkg::STAT_W-1:0]     status;
	logic [bpfla_pkg::BYTE_W-1:0]     payload_offset;
	logic [bpfla_pkg::BYTE_W-1:0]     copy_bytes;
	logic [bpfla_pkg::BYTE_W-1:0]     bytes_remaining;

	modport source(output valid, status, payload_offset, copy_bytes, bytes_remaining,
		input ready);
	modport sink(input valid, status, payload_offset, copy_bytes, bytes_remaining,
		output ready);
endinterface
`default_nettype wire

FILE: src/bpfla_cfg_if.sv
// Configuration write channel carrying the pool size.
`default_nettype none
interface bpfla_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bpfla_pkg::BYTE_W-1:0]     pool_size;

	modport source(output valid, pool_size, input ready);
	modport sink(input valid, pool_size, output ready);
endinterface
`default_nettype wire

FILE: src/bpfla_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module bpfla_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

FILE: src/byte_pool_free_list_allocator.sv
// Byte pool allocator: free table scan, downward stack and live block table.
// Free and realloc with a pointer walk the live table RAM, allocation walks the live
// valid bits and the free table, and a free table insert walks the free table again.
// One item in work at a time: next taken once the result is registered.
// Reset and a pool size write clear the free count, live valid bits and stack.
`default_nettype none
module byte_pool_free_list_allocator (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bpfla_cfg_if.sink      cfg,
	bpfla_cmd_if.sink      cmd,
	bpfla_rsp_if.source    rsp
);

	localparam int unsigned BW = bpfla_pkg::BYTE_W;
	localparam int unsigned OW = bpfla_pkg::OFFS_W;
	localparam int unsigned FI = bpfla_pkg::FIDX_W;
	localparam int unsigned FC = bpfla_pkg::FCNT_W;
	localparam int unsigned LI = bpfla_pkg::LIDX_W;
	localparam int unsigned LC = bpfla_pkg::LCNT_W;
	localparam int unsigned NF = bpfla_pkg::FREE_ENTRIES;
	localparam int unsigned NL = bpfla_pkg::LIVE_ENTRIES;

	bpfla_pkg::fsm_t state_q, state_d;

	// pool state
	bpfla_pkg::bytes_t ps_q, sb_q, rem_q;
	logic [FC-1:0]     cnt_q;
	bpfla_pkg::offs_t  fo_q [NF];
	bpfla_pkg::bytes_t fb_q [NF];
	logic [NL-1:0]     valid_q;

	// latched item
	logic [bpfla_pkg::OP_W-1:0] op_q;
	bpfla_pkg::bytes_t req_q, off_q, need_q;
	logic              has_q;

	// scan counters
	logic [LC-1:0] k_q;
	logic [LI-1:0] kidx_s1;
	logic          kval_s1;
	logic [FC-1:0] jc_q;

	// old block, new slot and take plan
	logic [LI-1:0]          old_slot_q, new_slot_q;
	bpfla_pkg::offs_t       old_hdr_q, tk_hdr_q;
	bpfla_pkg::bytes_t      old_blk_q, tk_blk_q, shrink_b_q;
	bpfla_pkg::take_mode_t  mode_q;
	logic [FI-1:0]          hit_q;

	// pending result
	bpfla_pkg::status_t res_status_q;
	bpfla_pkg::bytes_t  res_payload_q, res_copy_q;

	// output register
	logic               rsp_valid_q;
	bpfla_pkg::status_t rsp_status_q;
	bpfla_pkg::bytes_t  rsp_payload_q, rsp_copy_q, rsp_rem_q;

	// live table RAM
	bpfla_pkg::live_entry_t rd_ent, wr_ent;
	logic                   tk_commit;

	bpfla_ram #(
		.WIDTH($bits(bpfla_pkg::live_entry_t)),
		.DEPTH(NL)
	) u_live_ram (
		.clk    (clk),
		.wr_en  (tk_commit),
		.wr_addr(new_slot_q),
		.wr_data(wr_ent),
		.rd_addr(k_q[LI-1:0]),
		.rd_data(rd_ent)
	);

	assign wr_ent.hdr = tk_hdr_q;
	assign wr_ent.blk = tk_blk_q;

	// handshakes
	logic cfg_fire, cmd_fire, out_load;
	bpfla_pkg::bytes_t cfg_clamped;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cmd.ready = (state_q == bpfla_pkg::S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	always_comb begin
		cfg_clamped = cfg.pool_size;
		if (cfg.pool_size < BW'(bpfla_pkg::MIN_POOL)) begin
			cfg_clamped = BW'(bpfla_pkg::MIN_POOL);
		end else if (cfg.pool_size > BW'(bpfla_pkg::POOL_BYTES)) begin
			cfg_clamped = BW'(bpfla_pkg::POOL_BYTES);
		end
	end

	// datapath conditions
	logic take_zero, take_big, rel_needed;
	logic live_hit, live_last, lsrch_issue;
	logic slot_free, slot_last;
	logic fs_end, fs_fit, fs_whole, stack_short, ins_hit;
	bpfla_pkg::bytes_t fs_b, fs_rest, sb_post, copy_min;
	logic [FC-1:0] cnt_post;
	logic tk_fail, rc_stack, rc_full;

	assign take_zero  = (req_q == '0);
	assign take_big   = (req_q > ps_q);
	assign rel_needed = (op_q == bpfla_pkg::OP_REALLOC) && has_q;

	assign live_hit  = kval_s1 && valid_q[kidx_s1]
		&& ((BW'(rd_ent.hdr) + BW'(bpfla_pkg::HEADER_BYTES)) == off_q);
	assign live_last = kval_s1 && (kidx_s1 == LI'(NL - 1));
	assign lsrch_issue = (state_q == bpfla_pkg::S_LSRCH) && (k_q < LC'(NL)) && !live_hit;

	assign slot_free = !valid_q[k_q[LI-1:0]];
	assign slot_last = (k_q[LI-1:0] == LI'(NL - 1));

	assign fs_end      = (jc_q >= cnt_q);
	assign fs_b        = fb_q[jc_q[FI-1:0]];
	assign fs_fit      = (fs_b >= need_q);
	assign fs_whole    = ({1'b0, fs_b} <= ({1'b0, need_q} + (BW+1)'(bpfla_pkg::SPLIT_SLACK)));
	assign fs_rest     = fs_b - need_q;
	assign stack_short = (sb_q < need_q);
	assign ins_hit     = fs_end || (fs_b <= old_blk_q);

	// release check against the state the take would leave
	assign sb_post  = (mode_q == bpfla_pkg::TK_STACK) ? (sb_q - tk_blk_q) : sb_q;
	assign cnt_post = (mode_q == bpfla_pkg::TK_REMOVE) ? (cnt_q - FC'(1)) : cnt_q;
	assign tk_fail  = rel_needed && (BW'(old_hdr_q) != sb_post) && (cnt_post >= FC'(NF));
	assign rc_stack = (BW'(old_hdr_q) == sb_q);
	assign rc_full  = (cnt_q >= FC'(NF));
	assign copy_min = ((old_blk_q < tk_blk_q) ? old_blk_q : tk_blk_q)
		- BW'(bpfla_pkg::HEADER_BYTES);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpfla_pkg::S_IDLE: begin
				if (cmd_fire) state_d = bpfla_pkg::S_DISPATCH;
			end
			bpfla_pkg::S_DISPATCH: begin
				unique case (op_q)
					bpfla_pkg::OP_ALLOC:
						state_d = (take_zero || take_big) ? bpfla_pkg::S_DONE : bpfla_pkg::S_SLOT;
					bpfla_pkg::OP_FREE:
						state_d = has_q ? bpfla_pkg::S_LSRCH : bpfla_pkg::S_DONE;
					bpfla_pkg::OP_REALLOC: begin
						if (take_big) state_d = bpfla_pkg::S_DONE;
						else if (has_q) state_d = bpfla_pkg::S_LSRCH;
						else state_d = take_zero ? bpfla_pkg::S_DONE : bpfla_pkg::S_SLOT;
					end
					default: state_d = bpfla_pkg::S_DONE;
				endcase
			end
			bpfla_pkg::S_LSRCH: begin
				if (live_hit) begin
					if (op_q == bpfla_pkg::OP_FREE) state_d = bpfla_pkg::S_RCHK;
					else state_d = take_zero ? bpfla_pkg::S_DONE : bpfla_pkg::S_SLOT;
				end else if (live_last) begin
					state_d = bpfla_pkg::S_DONE;
				end
			end
			bpfla_pkg::S_SLOT: begin
				if (slot_free) state_d = bpfla_pkg::S_FSCAN;
				else if (slot_last) state_d = bpfla_pkg::S_DONE;
			end
			bpfla_pkg::S_FSCAN: begin
				if (fs_end) state_d = stack_short ? bpfla_pkg::S_DONE : bpfla_pkg::S_TCOMMIT;
				else if (fs_fit) state_d = bpfla_pkg::S_TCOMMIT;
			end
			bpfla_pkg::S_TCOMMIT: begin
				state_d = (!tk_fail && rel_needed) ? bpfla_pkg::S_RCHK : bpfla_pkg::S_DONE;
			end
			bpfla_pkg::S_RCHK: begin
				state_d = (rc_stack || rc_full) ? bpfla_pkg::S_DONE : bpfla_pkg::S_INS;
			end
			bpfla_pkg::S_INS: begin
				if (ins_hit) state_d = bpfla_pkg::S_DONE;
			end
			bpfla_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = bpfla_pkg::S_IDLE;
			end
			default: state_d = bpfla_pkg::S_IDLE;
		endcase
	end

	// sequencer strobes
	logic res_set, k_clr, k_inc, j_clr, j_inc, lat_old, slot_ld;
	logic plan_stack, plan_fit, rel_stack, rel_ins;
	bpfla_pkg::status_t res_code;

	always_comb begin
		res_set    = 1'b0;
		res_code   = bpfla_pkg::ST_OK;
		k_clr      = 1'b0;
		k_inc      = 1'b0;
		j_clr      = 1'b0;
		j_inc      = 1'b0;
		lat_old    = 1'b0;
		slot_ld    = 1'b0;
		plan_stack = 1'b0;
		plan_fit   = 1'b0;
		tk_commit  = 1'b0;
		rel_stack  = 1'b0;
		rel_ins    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			bpfla_pkg::S_IDLE: begin
			end
			bpfla_pkg::S_DISPATCH: begin
				k_clr = 1'b1;
				unique case (op_q)
					bpfla_pkg::OP_ALLOC: begin
						if (take_zero) begin
							res_set = 1'b1; res_code = bpfla_pkg::ST_REJECTED;
						end else if (take_big) begin
							res_set = 1'b1; res_code = bpfla_pkg::ST_NO_SPACE;
						end
					end
					bpfla_pkg::OP_FREE: begin
					end
					bpfla_pkg::OP_REALLOC: begin
						if (take_big) begin
							res_set = 1'b1; res_code = bpfla_pkg::ST_NO_SPACE;
						end else if (!has_q && take_zero) begin
							res_set = 1'b1; res_code = bpfla_pkg::ST_REJECTED;
						end
					end
					default: begin
						res_set = 1'b1; res_code = bpfla_pkg::ST_REJECTED;
					end
				endcase
			end
			bpfla_pkg::S_LSRCH: begin
				k_inc = lsrch_issue;
				if (live_hit) begin
					lat_old = 1'b1;
					k_clr   = 1'b1;
					if (op_q != bpfla_pkg::OP_FREE && take_zero) begin
						res_set = 1'b1; res_code = bpfla_pkg::ST_REJECTED;
					end
				end else if (live_last) begin
					res_set = 1'b1; res_code = bpfla_pkg::ST_REJECTED;
				end
			end
			bpfla_pkg::S_SLOT: begin
				if (slot_free) begin
					slot_ld = 1'b1;
					j_clr   = 1'b1;
				end else if (slot_last) begin
					res_set = 1'b1; res_code = bpfla_pkg::ST_LIVE_FULL;
				end else begin
					k_inc = 1'b1;
				end
			end
			bpfla_pkg::S_FSCAN: begin
				if (fs_end) begin
					if (stack_short) begin
						res_set = 1'b1; res_code = bpfla_pkg::ST_NO_SPACE;
					end else begin
						plan_stack = 1'b1;
					end
				end else if (fs_fit) begin
					plan_fit = 1'b1;
				end else begin
					j_inc = 1'b1;
				end
			end
			bpfla_pkg::S_TCOMMIT: begin
				if (tk_fail) begin
					res_set = 1'b1; res_code = bpfla_pkg::ST_FREE_FULL;
				end else begin
					tk_commit = 1'b1;
				end
			end
			bpfla_pkg::S_RCHK: begin
				if (rc_stack) begin
					rel_stack = 1'b1;
				end else if (rc_full) begin
					res_set = 1'b1; res_code = bpfla_pkg::ST_FREE_FULL;
				end else begin
					j_clr = 1'b1;
				end
			end
			bpfla_pkg::S_INS: begin
				if (ins_hit) rel_ins = 1'b1;
				else j_inc = 1'b1;
			end
			bpfla_pkg::S_DONE: begin
				out_load = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// control state, pool bookkeeping and live valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfla_pkg::S_IDLE;
			ps_q        <= BW'(bpfla_pkg::POOL_BYTES);
			sb_q        <= BW'(bpfla_pkg::POOL_BYTES);
			rem_q       <= BW'(bpfla_pkg::POOL_BYTES);
			cnt_q       <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
			jc_q        <= '0;
			kval_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			kval_s1 <= lsrch_issue;

			if (k_clr) k_q <= '0;
			else if (k_inc) k_q <= k_q + LC'(1);

			if (j_clr) jc_q <= '0;
			else if (j_inc) jc_q <= jc_q + FC'(1);

			if (cfg_fire) begin
				ps_q    <= cfg_clamped;
				sb_q    <= cfg_clamped;
				rem_q   <= cfg_clamped;
				cnt_q   <= '0;
				valid_q <= '0;
			end else if (tk_commit) begin
				case (mode_q)
					bpfla_pkg::TK_REMOVE: cnt_q <= cnt_q - FC'(1);
					bpfla_pkg::TK_STACK:  sb_q <= sb_q - tk_blk_q;
					default: begin
					end
				endcase
				rem_q <= rem_q - tk_blk_q;
				valid_q[new_slot_q] <= 1'b1;
			end else if (rel_stack) begin
				sb_q  <= sb_q + old_blk_q;
				rem_q <= rem_q + old_blk_q;
				valid_q[old_slot_q] <= 1'b0;
			end else if (rel_ins) begin
				cnt_q <= cnt_q + FC'(1);
				rem_q <= rem_q + old_blk_q;
				valid_q[old_slot_q] <= 1'b0;
			end

			if (out_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// item operands, take plan and result
	always_ff @(posedge clk) begin
		kidx_s1 <= k_q[LI-1:0];

		if (cmd_fire) begin
			op_q          <= cmd.operation;
			req_q         <= cmd.request_bytes;
			off_q         <= cmd.block_offset;
			has_q         <= cmd.has_pointer;
			need_q        <= cmd.request_bytes + BW'(bpfla_pkg::HEADER_BYTES);
			res_status_q  <= bpfla_pkg::ST_OK;
			res_payload_q <= '0;
			res_copy_q    <= '0;
		end else if (res_set) begin
			res_status_q <= res_code;
		end else if (tk_commit) begin
			res_payload_q <= BW'(tk_hdr_q) + BW'(bpfla_pkg::HEADER_BYTES);
			if (rel_needed) res_copy_q <= copy_min;
		end

		if (lat_old) begin
			old_slot_q <= kidx_s1;
			old_hdr_q  <= rd_ent.hdr;
			old_blk_q  <= rd_ent.blk;
		end

		if (slot_ld) new_slot_q <= k_q[LI-1:0];

		if (plan_stack) begin
			mode_q   <= bpfla_pkg::TK_STACK;
			tk_hdr_q <= OW'(sb_q - need_q);
			tk_blk_q <= need_q;
		end else if (plan_fit) begin
			hit_q <= jc_q[FI-1:0];
			if (fs_whole) begin
				mode_q   <= bpfla_pkg::TK_REMOVE;
				tk_hdr_q <= fo_q[jc_q[FI-1:0]];
				tk_blk_q <= fs_b;
			end else begin
				mode_q     <= bpfla_pkg::TK_SHRINK;
				tk_hdr_q   <= OW'(BW'(fo_q[jc_q[FI-1:0]]) + fs_rest);
				tk_blk_q   <= need_q;
				shrink_b_q <= fs_rest;
			end
		end

		if (out_load) begin
			rsp_status_q  <= res_status_q;
			rsp_payload_q <= res_payload_q;
			rsp_copy_q    <= res_copy_q;
			rsp_rem_q     <= rem_q;
		end
	end

	// free table: close the gap on removal, shrink an entry on a split, open one on insert
	always_ff @(posedge clk) begin
		if (tk_commit && mode_q == bpfla_pkg::TK_REMOVE) begin
			for (int i = 0; i < NF - 1; i++) begin
				if (FI'(i) >= hit_q) begin
					fo_q[i] <= fo_q[i+1];
					fb_q[i] <= fb_q[i+1];
				end
			end
		end else if (tk_commit && mode_q == bpfla_pkg::TK_SHRINK) begin
			fb_q[hit_q] <= shrink_b_q;
		end else if (rel_ins) begin
			for (int i = 1; i < NF; i++) begin
				if (FI'(i) > jc_q[FI-1:0]) begin
					fo_q[i] <= fo_q[i-1];
					fb_q[i] <= fb_q[i-1];
				end
			end
			fo_q[jc_q[FI-1:0]] <= old_hdr_q;
			fb_q[jc_q[FI-1:0]] <= old_blk_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.payload_offset  = rsp_payload_q;
	assign rsp.copy_bytes      = rsp_copy_q;
	assign rsp.bytes_remaining = rsp_rem_q;

endmodule
`default_nettype wire

FILE: tb/sv/byte_pool_free_list_allocator_tb.sv
// Self-checking testbench of the byte pool allocator: scoreboard predictor and random traffic.
`default_nettype none
module byte_pool_free_list_allocator_tb;

	localparam int unsigned WATCHDOG_CYCLES = 20000;
	localparam int unsigned DRAIN_CYCLES    = 300;

	localparam int unsigned OP_W         = bpfla_pkg::OP_W;
	localparam int unsigned BYTE_W       = bpfla_pkg::BYTE_W;
	localparam int unsigned STAT_W       = bpfla_pkg::STAT_W;
	localparam int unsigned POOL_BYTES   = bpfla_pkg::POOL_BYTES;
	localparam int unsigned MIN_POOL     = bpfla_pkg::MIN_POOL;
	localparam int unsigned HEADER_BYTES = bpfla_pkg::HEADER_BYTES;
	localparam int unsigned SPLIT_SLACK  = bpfla_pkg::SPLIT_SLACK;
	localparam int unsigned FREE_ENTRIES = bpfla_pkg::FREE_ENTRIES;
	localparam int unsigned LIVE_ENTRIES = bpfla_pkg::LIVE_ENTRIES;

	// Operation code the block does not define
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		bpfla_pkg::bytes_t   payload_offset;
		bpfla_pkg::bytes_t   copy_bytes;
		bpfla_pkg::bytes_t   bytes_remaining;
	} alloc_result_t;

	// Allocator state copy
	typedef struct {
		int unsigned pool_size;
		int unsigned stack_base;
		int unsigned free_off[FREE_ENTRIES];
		int unsigned free_len[FREE_ENTRIES];
		int unsigned free_count;
		int unsigned live_off[LIVE_ENTRIES];
		int unsigned live_len[LIVE_ENTRIES];
		bit          live_on[LIVE_ENTRIES];
		int unsigned remaining;
	} pool_model_t;

	logic clk;
	logic arst_n;

	bpfla_cfg_if cfg_ch();
	bpfla_cmd_if cmd_ch();
	bpfla_rsp_if rsp_ch();

	byte_pool_free_list_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	pool_model_t   pool;
	alloc_result_t pending_results[$];
	int unsigned   live_payloads[$];
	int unsigned   mismatches = 0;
	int unsigned   idle_cycles = 0;
	bit            timed_out = 1'b0;
	bit            stall_enable;
	int unsigned   burst_left;

	// Clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ---------------- predictor ----------------
	function automatic void pool_recreate(input int unsigned size);
		pool.pool_size  = size;
		pool.stack_base = size;
		pool.free_count = 0;
		pool.remaining  = size;
		foreach (pool.live_on[i]) pool.live_on[i] = 1'b0;
		live_payloads.delete();
	endfunction

	function automatic int find_live_slot(input int unsigned payload);
		for (int i = 0; i < LIVE_ENTRIES; i++)
			if (pool.live_on[i] && pool.live_off[i] + HEADER_BYTES == payload)
				return i;
		return -1;
	endfunction

	function automatic bpfla_pkg::status_t take_block(input int unsigned req, output int slot);
		int unsigned need;
		int unsigned b;
		int unsigned hdr;
		int unsigned blk;
		bit found;
		slot = -1;
		found = 1'b0;
		hdr = 0;
		blk = 0;
		if (req == 0) return bpfla_pkg::ST_REJECTED;
		if (req > pool.pool_size) return bpfla_pkg::ST_NO_SPACE;
		for (int i = 0; i < LIVE_ENTRIES; i++)
			if (!pool.live_on[i]) begin
				slot = i;
				break;
			end
		if (slot < 0) return bpfla_pkg::ST_LIVE_FULL;
		need = req + HEADER_BYTES;
		// First fit over the free table
		for (int i = 0; i < pool.free_count; i++) begin
			b = pool.free_len[i];
			if (b < need) continue;
			if (b <= need + SPLIT_SLACK) begin
				hdr = pool.free_off[i];
				blk = b;
				for (int j = i; j < FREE_ENTRIES - 1; j++) begin
					pool.free_off[j] = pool.free_off[j+1];
					pool.free_len[j] = pool.free_len[j+1];
				end
				pool.free_count--;
			end else begin
				pool.free_len[i] = b - need;
				hdr = pool.free_off[i] + (b - need);
				blk = need;
			end
			found = 1'b1;
			break;
		end
		if (!found) begin
			if (pool.stack_base < need) return bpfla_pkg::ST_NO_SPACE;
			pool.stack_base -= need;
			hdr = pool.stack_base;
			blk = need;
		end
		pool.remaining -= blk;
		pool.live_off[slot] = hdr;
		pool.live_len[slot] = blk;
		pool.live_on[slot] = 1'b1;
		return bpfla_pkg::ST_OK;
	endfunction

	function automatic bpfla_pkg::status_t release_block(input int slot);
		int unsigned hdr;
		int unsigned blk;
		int unsigned pos;
		hdr = pool.live_off[slot];
		blk = pool.live_len[slot];
		if (hdr == pool.stack_base) begin
			pool.stack_base += blk;
		end else begin
			if (pool.free_count >= FREE_ENTRIES) return bpfla_pkg::ST_FREE_FULL;
			pos = pool.free_count;
			for (int i = 0; i < pool.free_count; i++)
				if (pool.free_len[i] <= blk) begin
					pos = i;
					break;
				end
			for (int j = pool.free_count; j > pos; j--) begin
				pool.free_off[j] = pool.free_off[j-1];
				pool.free_len[j] = pool.free_len[j-1];
			end
			pool.free_off[pos] = hdr;
			pool.free_len[pos] = blk;
			pool.free_count++;
		end
		pool.live_on[slot] = 1'b0;
		pool.remaining += blk;
		return bpfla_pkg::ST_OK;
	endfunction

	function automatic void forget_payload(input int unsigned payload);
		foreach (live_payloads[i])
			if (live_payloads[i] == payload) begin
				live_payloads.delete(i);
				return;
			end
	endfunction

	function automatic alloc_result_t predict_result(input logic [OP_W-1:0] op,
			input int unsigned req, input int unsigned offs, input bit has_ptr);
		alloc_result_t       r;
		pool_model_t         saved;
		bpfla_pkg::status_t  st;
		int                  slot;
		int                  old;
		int unsigned         ob;
		int unsigned         nb;
		int unsigned         payload;
		int unsigned         copy;
		st = bpfla_pkg::ST_OK;
		payload = 0;
		copy = 0;
		slot = -1;
		if (op == bpfla_pkg::OP_ALLOC) begin
			st = take_block(req, slot);
			if (st == bpfla_pkg::ST_OK) payload = pool.live_off[slot] + HEADER_BYTES;
		end else if (op == bpfla_pkg::OP_FREE) begin
			if (has_ptr) begin
				old = find_live_slot(offs);
				if (old < 0) st = bpfla_pkg::ST_REJECTED;
				else st = release_block(old);
				if (old >= 0 && st == bpfla_pkg::ST_OK) forget_payload(offs);
			end
		end else if (op == bpfla_pkg::OP_REALLOC) begin
			if (req > pool.pool_size) begin
				st = bpfla_pkg::ST_NO_SPACE;
			end else if (!has_ptr) begin
				st = take_block(req, slot);
				if (st == bpfla_pkg::ST_OK) payload = pool.live_off[slot] + HEADER_BYTES;
			end else begin
				old = find_live_slot(offs);
				if (old < 0) begin
					st = bpfla_pkg::ST_REJECTED;
				end else begin
					saved = pool;
					st = take_block(req, slot);
					if (st == bpfla_pkg::ST_OK) begin
						ob = pool.live_len[old];
						nb = pool.live_len[slot];
						st = release_block(old);
						if (st != bpfla_pkg::ST_OK) begin
							pool = saved;
						end else begin
							payload = pool.live_off[slot] + HEADER_BYTES;
							copy = (ob < nb ? ob : nb) - HEADER_BYTES;
							forget_payload(offs);
						end
					end
				end
			end
		end else begin
			st = bpfla_pkg::ST_REJECTED;
		end
		if (payload != 0) live_payloads.push_back(payload);
		r.status          = st;
		r.payload_offset  = payload[BYTE_W-1:0];
		r.copy_bytes      = copy[BYTE_W-1:0];
		r.bytes_remaining = pool.remaining[BYTE_W-1:0];
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic send_item(input logic [OP_W-1:0] op, input int unsigned req,
			input int unsigned offs, input bit has_ptr);
		// Burst and gap shaping
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		// Valid is dropped between consecutive items
		@(negedge clk);
		cmd_ch.valid         <= 1'b1;
		cmd_ch.operation     <= op;
		cmd_ch.request_bytes <= req[BYTE_W-1:0];
		cmd_ch.block_offset  <= offs[BYTE_W-1:0];
		cmd_ch.has_pointer   <= has_ptr;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pending_results.push_back(predict_result(op, req[BYTE_W-1:0], offs[BYTE_W-1:0],
			has_ptr));
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0 && !timed_out) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_pool_size(input int unsigned value);
		int unsigned v;
		wait_drained();
		cfg_ch.valid     <= 1'b1;
		cfg_ch.pool_size <= value[BYTE_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		v = value[BYTE_W-1:0];
		if (v < MIN_POOL) v = MIN_POOL;
		if (v > POOL_BYTES) v = POOL_BYTES;
		pool_recreate(v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic int unsigned pick_live();
		if (live_payloads.size() == 0) return HEADER_BYTES;
		return live_payloads[$urandom_range(0, live_payloads.size() - 1)];
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 2 * POOL_BYTES - 1);
			1, 2:    return $urandom_range(1, 4096);
			default: return $urandom_range(1, 400);
		endcase
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		send_item(bpfla_pkg::OP_ALLOC, 0, 0, 1'b0);
		send_item(OP_UNKNOWN, 10, 0, 1'b1);
		send_item(bpfla_pkg::OP_ALLOC, POOL_BYTES + 1, 0, 1'b0);
		send_item(bpfla_pkg::OP_ALLOC, 2 * POOL_BYTES - 1, 0, 1'b0);
		send_item(bpfla_pkg::OP_FREE, 0, 0, 1'b0);
		send_item(bpfla_pkg::OP_FREE, 0, 2 * POOL_BYTES - 1, 1'b1);
		send_item(bpfla_pkg::OP_ALLOC, 100, 0, 1'b0);
		send_item(bpfla_pkg::OP_ALLOC, 200, 0, 1'b0);
		send_item(bpfla_pkg::OP_ALLOC, 50, 0, 1'b0);
		// Free the middle one: goes to the free table
		send_item(bpfla_pkg::OP_FREE, 0, live_payloads[1], 1'b1);
		// Fits whole within slack, then a split
		send_item(bpfla_pkg::OP_ALLOC, 195, 0, 1'b0);
		send_item(bpfla_pkg::OP_FREE, 0, live_payloads[$], 1'b1);
		send_item(bpfla_pkg::OP_ALLOC, 40, 0, 1'b0);
		send_item(bpfla_pkg::OP_REALLOC, 30, 0, 1'b0);
		send_item(bpfla_pkg::OP_REALLOC, 500, live_payloads[0], 1'b1);
		send_item(bpfla_pkg::OP_REALLOC, 20, 12345, 1'b1);
		send_item(bpfla_pkg::OP_REALLOC, POOL_BYTES + 5, live_payloads[0], 1'b1);
		send_item(bpfla_pkg::OP_ALLOC, POOL_BYTES, 0, 1'b0);
		// Stack top free returns to the stack
		send_item(bpfla_pkg::OP_FREE, 0, live_payloads[$], 1'b1);
	endtask

	task automatic test_min_pool();
		write_pool_size(0);
		send_item(bpfla_pkg::OP_ALLOC, 1, 0, 1'b0);
		send_item(bpfla_pkg::OP_ALLOC, 2, 0, 1'b0);
		send_item(bpfla_pkg::OP_ALLOC, 25, 0, 1'b0);
		send_item(bpfla_pkg::OP_FREE, 0, HEADER_BYTES, 1'b1);
		write_pool_size(2 * POOL_BYTES - 1);
	endtask

	// Fill the live table and the free table
	task automatic test_tables_full();
		write_pool_size(POOL_BYTES);
		repeat (LIVE_ENTRIES + 2)
			send_item(bpfla_pkg::OP_ALLOC, $urandom_range(1, 200), 0, 1'b0);
		for (int i = 0; i < LIVE_ENTRIES; i += 2)
			if (i < live_payloads.size())
				send_item(bpfla_pkg::OP_FREE, 0, live_payloads[i], 1'b1);
		repeat (12) send_item(bpfla_pkg::OP_FREE, 0, pick_live(), 1'b1);
		repeat (6) send_item(bpfla_pkg::OP_REALLOC, $urandom_range(1, 300), pick_live(), 1'b1);
	endtask

	task automatic test_random(input int unsigned count);
		int unsigned kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40)
				send_item(bpfla_pkg::OP_ALLOC, pick_size(), 0, 1'b0);
			else if (kind < 75)
				send_item(bpfla_pkg::OP_FREE, 0, pick_live(), 1'b1);
			else if (kind < 90)
				send_item(bpfla_pkg::OP_REALLOC, pick_size(), pick_live(),
					$urandom_range(0, 3) != 0);
			else
				send_item(OP_W'($urandom_range(0, 3)), $urandom_range(0, 2 * POOL_BYTES - 1),
					$urandom_range(0, 2 * POOL_BYTES - 1), $urandom_range(0, 1) != 0);
			if (n == count / 2) wait_drained();
		end
	endtask

	// ---------------- receiver stall pattern ----------------
	always @(negedge clk) begin
		if (!stall_enable)
			rsp_ch.ready <= 1'b1;
		else
			rsp_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		alloc_result_t exp_r;
		alloc_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status          = rsp_ch.status;
			got.payload_offset  = rsp_ch.payload_offset;
			got.copy_bytes      = rsp_ch.copy_bytes;
			got.bytes_remaining = rsp_ch.bytes_remaining;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", exp_r, got);
				end
			end
		end
	end

	// Watchdog on accepted traffic
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = '0;
		cmd_ch.request_bytes = '0;
		cmd_ch.block_offset = '0;
		cmd_ch.has_pointer = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pool_size = '0;
		stall_enable = 1'b0;
		burst_left = 0;
		pool_recreate(POOL_BYTES);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		stall_enable = 1'b1;
		test_min_pool();
		test_tables_full();
		write_pool_size(3000);
		test_random(500);
		stall_enable = 1'b0;
		write_pool_size(POOL_BYTES);
		test_random(600);
		stall_enable = 1'b1;
		write_pool_size($urandom_range(MIN_POOL, POOL_BYTES));
		test_random(650);
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
